FILE: rtl/stepping_rotor_cipher_unit_macros.svh
`ifndef STEPPING_ROTOR_CIPHER_UNIT_MACROS_SVH
`define STEPPING_ROTOR_CIPHER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SRC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/src_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package src_pkg;

	localparam int unsigned ALPHABET = 26;
	localparam int unsigned LAST_INDEX = 25;
	localparam logic [7:0] LETTER_BASE = 8'd65;
	localparam logic [7:0] LETTER_END = 8'd91;

	// configuration register indexes
	localparam logic REG_ROTOR_COUNT = 1'b0;
	localparam logic REG_DECRYPT = 1'b1;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W = 2;

	// rotor count codes
	localparam logic [1:0] ROTORS_ONE = 2'd1;
	localparam logic [1:0] ROTORS_TWO = 2'd2;

	typedef logic [4:0] digit_t;

	// forward rotor tables
	localparam logic [7:0] ROTOR_ONE [ALPHABET] = '{
		"G", "W", "Q", "R", "U", "E", "Y", "N", "O", "J", "A", "K", "Z",
		"L", "S", "B", "I", "V", "C", "X", "D", "H", "F", "M", "P", "T"
	};
	localparam logic [7:0] ROTOR_TWO [ALPHABET] = '{
		"O", "A", "Z", "I", "J", "L", "D", "U", "Y", "M", "F", "V", "K",
		"R", "T", "Q", "B", "E", "H", "S", "P", "G", "W", "X", "C", "N"
	};

	// inverse tables: letter index to its position in the rotor
	localparam digit_t INV_ONE [ALPHABET] = '{
		5'd10, 5'd15, 5'd18, 5'd20, 5'd5,  5'd22, 5'd0,  5'd21, 5'd16,
		5'd9,  5'd11, 5'd13, 5'd23, 5'd7,  5'd8,  5'd24, 5'd2,  5'd3,
		5'd14, 5'd25, 5'd4,  5'd17, 5'd1,  5'd19, 5'd6,  5'd12
	};
	localparam digit_t INV_TWO [ALPHABET] = '{
		5'd1,  5'd16, 5'd24, 5'd6,  5'd17, 5'd10, 5'd21, 5'd18, 5'd3,
		5'd4,  5'd12, 5'd5,  5'd9,  5'd25, 5'd0,  5'd20, 5'd15, 5'd13,
		5'd19, 5'd14, 5'd7,  5'd11, 5'd22, 5'd23, 5'd8,  5'd2
	};

	// configuration as seen by the transform stage
	typedef struct packed {
		logic [1:0] rotor_count;
		logic       decrypt;
	} src_cfg_t;

	// one request after the position stage
	typedef struct packed {
		logic [7:0] data;
		digit_t     pos_low;
		digit_t     pos_high;
	} src_item_t;

	// add two digits modulo 26
	function automatic digit_t add26(input digit_t a, input digit_t b);
		logic [5:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= 6'(ALPHABET)) begin
			sum = sum - 6'(ALPHABET);
		end
		return sum[4:0];
	endfunction

	// subtract two digits modulo 26
	function automatic digit_t sub26(input digit_t a, input digit_t b);
		logic [5:0] diff;
		if (a >= b) begin
			diff = {1'b0, a} - {1'b0, b};
		end else begin
			diff = {1'b0, a} + 6'(ALPHABET) - {1'b0, b};
		end
		return diff[4:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/src_position.sv
`timescale 1ns / 1ps
`default_nettype none

module src_position import src_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic [7:0] byte_in,
	input  wire logic      message_start,
	output logic           valid_s1,
	input  wire logic      ready_s1,
	output src_item_t      item_s1
);

	digit_t pos_low_q;
	digit_t pos_high_q;
	digit_t base_low;
	digit_t base_high;
	logic   in_fire;

	assign in_ready = !valid_s1 || ready_s1;
	assign in_fire = in_valid && in_ready;

	// clear the counter ahead of a message start
	always_comb begin
		base_low = message_start ? '0 : pos_low_q;
		base_high = message_start ? '0 : pos_high_q;
	end

	// advance the two-digit counter on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_low_q <= '0;
			pos_high_q <= '0;
		end else if (in_fire) begin
			if (base_low >= 5'(LAST_INDEX)) begin
				pos_low_q <= '0;
				pos_high_q <= (base_high >= 5'(LAST_INDEX)) ? '0 : base_high + 5'd1;
			end else begin
				pos_low_q <= base_low + 5'd1;
				pos_high_q <= base_high;
			end
		end
	end

	// hold the stage valid until the transform takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// capture the byte with the position it uses
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.data <= byte_in;
			item_s1.pos_low <= base_low;
			item_s1.pos_high <= base_high;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/src_transform.sv
`timescale 1ns / 1ps
`default_nettype none

module src_transform import src_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire src_cfg_t  cfg,
	input  wire logic      valid_s1,
	output logic           ready_s1,
	input  wire src_item_t item_s1,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [7:0]     byte_out
);

	logic       is_letter;
	logic       rotor_ok;
	digit_t     letter_idx;
	digit_t     offset;
	digit_t     enc_idx;
	digit_t     dec_pos;
	digit_t     dec_idx;
	logic [7:0] result;
	logic [7:0] byte_out_q;

	assign ready_s1 = !out_valid || out_ready;

	// pick the offset and transform uppercase letters
	always_comb begin
		is_letter = (item_s1.data >= LETTER_BASE) && (item_s1.data < LETTER_END);
		rotor_ok = (cfg.rotor_count == ROTORS_ONE) || (cfg.rotor_count == ROTORS_TWO);
		letter_idx = 5'(item_s1.data - LETTER_BASE);
		if (cfg.rotor_count == ROTORS_TWO) begin
			offset = add26(item_s1.pos_low, item_s1.pos_high);
			dec_pos = INV_TWO[letter_idx];
		end else begin
			offset = item_s1.pos_low;
			dec_pos = INV_ONE[letter_idx];
		end
		enc_idx = add26(letter_idx, offset);
		dec_idx = sub26(dec_pos, offset);
		result = item_s1.data;
		if (is_letter && rotor_ok) begin
			if (cfg.decrypt) begin
				result = LETTER_BASE + {3'b000, dec_idx};
			end else if (cfg.rotor_count == ROTORS_TWO) begin
				result = ROTOR_TWO[enc_idx];
			end else begin
				result = ROTOR_ONE[enc_idx];
			end
		end
	end

	// hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s1) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			byte_out_q <= result;
		end
	end

	assign byte_out = byte_out_q;

endmodule

`default_nettype wire

FILE: rtl/stepping_rotor_cipher_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Stepping rotor cipher: one byte in, one byte out, one byte per cycle
// unless out_ready stalls; position and transform stages register it.
// A two-digit base-26 position counter (period 676) steps each byte; a byte
// flagged message_start clears it first and then uses position zero.
// Only bytes 'A'..'Z' are changed; rotor_count 1 selects the first rotor
// with the low digit as offset, 2 the second rotor with both digits, and
// any other value passes every byte through. decrypt selects the inverse
// mapping. Write the configuration only while no request is in flight;
// register 0 is rotor_count, register 1 is decrypt.
module stepping_rotor_cipher_unit import src_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            byte_in,
	input  wire logic                  message_start,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 byte_out
);

	src_cfg_t  cfg_q;
	logic      valid_s1;
	logic      ready_s1;
	src_item_t item_s1;

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotor_count <= ROTORS_ONE;
			cfg_q.decrypt <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROTOR_COUNT: cfg_q.rotor_count <= cfg_data[1:0];
				REG_DECRYPT:     cfg_q.decrypt <= cfg_data[0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	src_position u_position (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_in       (byte_in),
		.message_start (message_start),
		.valid_s1      (valid_s1),
		.ready_s1      (ready_s1),
		.item_s1       (item_s1)
	);

	src_transform u_transform (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.ready_s1  (ready_s1),
		.item_s1   (item_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.byte_out  (byte_out)
	);

endmodule

`default_nettype wire

FILE: rtl/src_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stepping_rotor_cipher_unit_macros.svh"

module src_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] byte_out
);

	// a stalled result holds
	`SRC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(byte_out), "result moved")

	// an empty output side always takes a request
	`SRC_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

	// out_valid follows every accepted request through the position and transform registers
	`SRC_ASSERT(a_latency, in_valid && in_ready |=> ##1 out_valid, "no result after request")

	// reset empties the output
	`SRC_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind stepping_rotor_cipher_unit src_checker u_src_checker (.*);

`default_nettype wire

FILE: sim/tb_stepping_rotor_cipher_unit.sv
`timescale 1ns / 1ps

module tb_stepping_rotor_cipher_unit;
	import src_pkg::*;

	// rotor_count values that leave every byte untouched
	localparam logic [1:0] ROTORS_OFF_LOW = 2'd0;
	localparam logic [1:0] ROTORS_OFF_HIGH = 2'd3;
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	localparam logic [7:0] CAP_A = 8'd65;
	localparam logic [7:0] CAP_Z = 8'd90;
	localparam int LETTER_COUNT = 26;
	localparam logic [8*26-1:0] WHEEL_ONE = "GWQRUEYNOJAKZLSBIVCXDHFMPT";
	localparam logic [8*26-1:0] WHEEL_TWO = "OAZIJLDUYMFVKRTQBEHSPGWXCN";

	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [1:0] rotors;
		logic       mode;
		logic [7:0] data;
		logic       start;
		logic       typed;
		logic [7:0] want;
	} stim_row_t;

	// directed requests; typed rows carry their result, the rest use the predictor
	localparam int DIRECTED_COUNT = 19;
	localparam stim_row_t DIRECTED [DIRECTED_COUNT] = '{
		'{ROTORS_ONE, MODE_ENCRYPT, "A", 1'b1, 1'b1, "G"},
		'{ROTORS_ONE, MODE_ENCRYPT, "Z", 1'b0, 1'b1, "G"},
		'{ROTORS_ONE, MODE_ENCRYPT, 8'h00, 1'b0, 1'b1, 8'h00},
		'{ROTORS_ONE, MODE_ENCRYPT, 8'hFF, 1'b0, 1'b1, 8'hFF},
		'{ROTORS_ONE, MODE_ENCRYPT, "@", 1'b0, 1'b1, "@"},
		'{ROTORS_ONE, MODE_ENCRYPT, "[", 1'b0, 1'b1, "["},
		'{ROTORS_ONE, MODE_ENCRYPT, "a", 1'b0, 1'b1, "a"},
		'{ROTORS_ONE, MODE_ENCRYPT, "M", 1'b0, 1'b0, 8'h00},
		'{ROTORS_ONE, MODE_DECRYPT, "G", 1'b1, 1'b1, "A"},
		'{ROTORS_ONE, MODE_DECRYPT, "T", 1'b0, 1'b0, 8'h00},
		'{ROTORS_TWO, MODE_ENCRYPT, "A", 1'b1, 1'b1, "O"},
		'{ROTORS_TWO, MODE_ENCRYPT, "Z", 1'b0, 1'b1, "O"},
		'{ROTORS_TWO, MODE_DECRYPT, "O", 1'b1, 1'b1, "A"},
		'{ROTORS_TWO, MODE_DECRYPT, "N", 1'b0, 1'b0, 8'h00},
		'{ROTORS_OFF_LOW, MODE_ENCRYPT, "A", 1'b0, 1'b1, "A"},
		'{ROTORS_OFF_LOW, MODE_ENCRYPT, "Q", 1'b0, 1'b1, "Q"},
		'{ROTORS_OFF_HIGH, MODE_DECRYPT, "A", 1'b0, 1'b1, "A"},
		'{ROTORS_OFF_HIGH, MODE_DECRYPT, "Z", 1'b0, 1'b1, "Z"},
		'{ROTORS_ONE, MODE_ENCRYPT, 8'h80, 1'b1, 1'b1, 8'h80}
	};

	// settings of the random phases; the last one runs without idling
	localparam logic [1:0] PHASE_ROTORS [PHASE_COUNT] = '{
		ROTORS_ONE, ROTORS_TWO, ROTORS_ONE, ROTORS_OFF_HIGH, ROTORS_OFF_LOW, ROTORS_TWO
	};
	localparam logic PHASE_MODE [PHASE_COUNT] = '{
		MODE_ENCRYPT, MODE_DECRYPT, MODE_DECRYPT, MODE_ENCRYPT, MODE_DECRYPT, MODE_ENCRYPT
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] byte_in = 8'h00;
	logic message_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] byte_out;

	// predictor state and configuration
	logic [1:0] cur_rotors = ROTORS_ONE;
	logic cur_mode = MODE_ENCRYPT;
	digit_t wheel_low = '0;
	digit_t wheel_high = '0;

	logic [7:0] expected_bytes [$];
	logic [7:0] due_byte;
	int mismatches = 0;
	bit calm = 1'b0;

	stepping_rotor_cipher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_in(byte_in),
		.message_start(message_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_out(byte_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] wheel_letter(input logic [1:0] sel, input int k);
		if (sel == ROTORS_ONE) begin
			return WHEEL_ONE[8*(LETTER_COUNT-1-k) +: 8];
		end
		return WHEEL_TWO[8*(LETTER_COUNT-1-k) +: 8];
	endfunction

	function automatic int wheel_position(input logic [1:0] sel, input logic [7:0] letter);
		for (int k = 0; k < LETTER_COUNT; k++) begin
			if (wheel_letter(sel, k) == letter) begin
				return k;
			end
		end
		return 0;
	endfunction

	// cipher one byte at the current position, then step the position
	function automatic logic [7:0] next_cipher_byte(input logic [7:0] b, input logic start);
		int shift;
		int idx;
		logic [7:0] res;
		if (start) begin
			wheel_low = '0;
			wheel_high = '0;
		end
		res = b;
		if (b >= CAP_A && b <= CAP_Z && (cur_rotors == ROTORS_ONE || cur_rotors == ROTORS_TWO)) begin
			if (cur_rotors == ROTORS_ONE) begin
				shift = int'(wheel_low);
			end else begin
				shift = (int'(wheel_low) + int'(wheel_high)) % LETTER_COUNT;
			end
			if (cur_mode == MODE_DECRYPT) begin
				idx = wheel_position(cur_rotors, b);
				res = 8'(int'(CAP_A) + (idx + LETTER_COUNT - shift) % LETTER_COUNT);
			end else begin
				res = wheel_letter(cur_rotors, (int'(b) - int'(CAP_A) + shift) % LETTER_COUNT);
			end
		end
		if (wheel_low == digit_t'(LETTER_COUNT - 1)) begin
			wheel_low = '0;
			wheel_high = (wheel_high == digit_t'(LETTER_COUNT - 1)) ? '0 : wheel_high + 1'b1;
		end else begin
			wheel_low = wheel_low + 1'b1;
		end
		return res;
	endfunction

	// hold one request until accepted, then queue its result and maybe idle
	task automatic send_byte(input logic [7:0] b, input logic start, input logic typed,
			input logic [7:0] want);
		logic [7:0] predicted;
		in_valid <= 1'b1;
		byte_in <= b;
		message_start <= start;
		do @(posedge clk); while (!in_ready);
		predicted = next_cipher_byte(b, start);
		expected_bytes.push_back(typed ? want : predicted);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// drop valid and wait until every queued result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == REG_ROTOR_COUNT) begin
			cur_rotors = value;
		end else begin
			cur_mode = value[0];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// change the configuration only while the block is idle
	task automatic apply_setting(input logic [1:0] rotors, input logic mode);
		if (rotors != cur_rotors || mode != cur_mode) begin
			drain();
			if (rotors != cur_rotors) begin
				write_reg(REG_ROTOR_COUNT, rotors);
			end
			if (mode != cur_mode) begin
				write_reg(REG_DECRYPT, {1'b0, mode});
			end
		end
	endtask

	// stimulus
	initial begin
		logic [7:0] b;
		logic start;
		int guard;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_COUNT; r++) begin
			apply_setting(DIRECTED[r].rotors, DIRECTED[r].mode);
			send_byte(DIRECTED[r].data, DIRECTED[r].start, DIRECTED[r].typed, DIRECTED[r].want);
		end

		// mostly letters; message starts only late so the counter wraps fully
		for (int p = 0; p < PHASE_COUNT; p++) begin
			apply_setting(PHASE_ROTORS[p], PHASE_MODE[p]);
			calm = (p == PHASE_COUNT - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) < 7) begin
					b = 8'(int'(CAP_A) + $urandom_range(0, LETTER_COUNT - 1));
				end else begin
					b = 8'($urandom_range(0, 255));
				end
				start = (p >= PHASE_COUNT - 2) && ($urandom_range(0, 49) == 0);
				send_byte(b, start, 1'b0, 8'h00);
			end
		end

		in_valid <= 1'b0;
		guard = 0;
		while (expected_bytes.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			$error("byte_out: %0d results never arrived", expected_bytes.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// result side: stall in bursts, run freely at the end
	initial begin
		@(posedge arst_n);
		forever begin
			if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$error("byte_out: unexpected result, actual %h", byte_out);
				mismatches++;
			end else begin
				due_byte = expected_bytes.pop_front();
				if (byte_out !== due_byte) begin
					$error("byte_out: expected %h, actual %h", due_byte, byte_out);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: stepping_rotor_cipher_unit.f
+incdir+rtl
rtl/src_pkg.sv
rtl/src_position.sv
rtl/src_transform.sv
rtl/stepping_rotor_cipher_unit.sv
rtl/src_checker.sv
sim/tb_stepping_rotor_cipher_unit.sv
